/* design/mmbd_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, register indexes and the queue item type of the
// min/max bucket decimator. No dependencies.
package mmbd_pkg;

  localparam int unsigned MAX_PIXELS  = 4096;
  localparam int unsigned VALUE_BITS  = 32;
  localparam int unsigned TIME_BITS   = 32;
  localparam int unsigned WIDTH_BITS  = 13;
  localparam int unsigned COUNT_BITS  = 32;
  localparam int unsigned BUCKET_BITS = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  // One extra quotient bit tells a column index at or past the pixel width.
  localparam int unsigned QUOT_BITS   = BUCKET_BITS + 1;
  localparam int unsigned DIV_CNT_BITS = $clog2(QUOT_BITS);
  localparam int unsigned PROD_BITS   = TIME_BITS + WIDTH_BITS;
  localparam int unsigned LIM_BITS    = TIME_BITS + QUOT_BITS;
  localparam int unsigned NUM_BITS    = (PROD_BITS > LIM_BITS) ? PROD_BITS : LIM_BITS;

  localparam int unsigned CFG_ADDR_BITS = 4;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_WINDOW_START = CFG_ADDR_BITS'(0);
  localparam logic [CFG_ADDR_BITS-1:0] CFG_WINDOW_SPAN  = CFG_ADDR_BITS'(1);
  localparam logic [CFG_ADDR_BITS-1:0] CFG_PIXEL_WIDTH  = CFG_ADDR_BITS'(2);
  localparam logic [CFG_ADDR_BITS-1:0] CFG_SAMPLE_COUNT = CFG_ADDR_BITS'(3);

  localparam int unsigned FIFO_DEPTH    = 2;
  localparam int unsigned FIFO_PTR_BITS = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

  // One classified sample as it travels from the front end to the back end.
  typedef struct packed {
    logic [TIME_BITS-1:0]         stamp;
    logic signed [VALUE_BITS-1:0] value;
    logic                         last;
    logic                         pass;
    logic [BUCKET_BITS-1:0]       bucket;
  } item_t;

endpackage

/* design/mmbd_fifo.sv */
`timescale 1ns / 1ps
// Short request queue between the classifying front end and the back end.
// Depends on mmbd_pkg.
module mmbd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mmbd_pkg::item_t item_i,
  output logic           full_o,
  input  logic           pop_i,
  output mmbd_pkg::item_t item_o,
  output logic           empty_o
);
  import mmbd_pkg::*;

  item_t                    mem [FIFO_DEPTH];
  logic [FIFO_PTR_BITS-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_BITS-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_BITS-1:0] count_q, count_d;

  localparam logic [FIFO_PTR_BITS-1:0] PTR_LAST = FIFO_PTR_BITS'(FIFO_DEPTH - 1);

  assign full_o  = (count_q == FIFO_CNT_BITS'(FIFO_DEPTH));
  assign empty_o = (count_q == '0);
  assign item_o  = mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + FIFO_PTR_BITS'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + FIFO_PTR_BITS'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + FIFO_CNT_BITS'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - FIFO_CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_ptr_q] <= item_i;
    end
  end

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("queue pushed while full");
  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("queue popped while empty");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FIFO_CNT_BITS'(FIFO_DEPTH)) else $error("queue count overflow");

endmodule

/* design/mmbd_front.sv */
`timescale 1ns / 1ps
// Front end: configuration registers, sample intake, passthrough test and
// column index by a multiply and a bit-serial divider. Depends on mmbd_pkg.
module mmbd_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [mmbd_pkg::CFG_ADDR_BITS-1:0]  cfg_index_i,
  input  logic [31:0]                         cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [mmbd_pkg::TIME_BITS-1:0]      sample_time_i,
  input  logic signed [mmbd_pkg::VALUE_BITS-1:0] sample_value_i,
  input  logic                                last_sample_i,
  output logic                                push_o,
  output mmbd_pkg::item_t                     push_item_o,
  input  logic                                full_i
);
  import mmbd_pkg::*;

  typedef enum logic [2:0] {F_IDLE, F_MUL, F_CHK, F_DIV, F_PUSH} state_e;

  state_e state_q, state_d;
  logic [DIV_CNT_BITS-1:0] div_cnt_q, div_cnt_d;

  logic [TIME_BITS-1:0]  window_start_q;
  logic [TIME_BITS-1:0]  window_span_q;
  logic [WIDTH_BITS-1:0] pixel_width_q;
  logic [COUNT_BITS-1:0] sample_count_q;

  logic [TIME_BITS-1:0]         stamp_q;
  logic signed [VALUE_BITS-1:0] value_q;
  logic                         last_q;
  logic                         pass_q;
  logic [BUCKET_BITS-1:0]       bucket_q;
  logic [TIME_BITS-1:0]         diff_q;
  logic [NUM_BITS-1:0]          prod_q;
  logic [TIME_BITS-1:0]         rem_q;
  logic [QUOT_BITS-1:0]         lo_q;
  logic [QUOT_BITS-1:0]         quo_q;

  logic [WIDTH_BITS-1:0]   w_eff, w_m1;
  logic [WIDTH_BITS+1:0]   w_x3;
  logic [TIME_BITS-1:0]    span_eff;
  logic                    pass, below, accept, sat;
  logic [NUM_BITS-1:0]     lim;
  logic [TIME_BITS:0]      rem_ext, span_ext;
  logic                    div_ge;
  logic [TIME_BITS-1:0]    rem_next;
  logic [QUOT_BITS-1:0]    quo_next;
  logic [BUCKET_BITS-1:0]  bucket_div;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != F_IDLE);
  assign accept      = in_valid_i && (state_q == F_IDLE);
  assign push_o      = (state_q == F_PUSH) && !full_i;
  assign push_item_o = '{stamp: stamp_q, value: value_q, last: last_q,
                         pass: pass_q, bucket: bucket_q};

  always_comb begin
    w_eff    = (32'(pixel_width_q) > 32'(MAX_PIXELS)) ? WIDTH_BITS'(MAX_PIXELS)
                                                       : pixel_width_q;
    w_m1     = w_eff - WIDTH_BITS'(1);
    w_x3     = ({2'b00, w_eff} << 1) + {2'b00, w_eff};
    span_eff = (window_span_q == '0) ? TIME_BITS'(1) : window_span_q;
    pass     = (w_eff == '0) || (sample_count_q <= COUNT_BITS'(w_x3));
    below    = sample_time_i < window_start_q;
    // A quotient at or above 2^QUOT_BITS is past every column.
    lim      = NUM_BITS'({span_eff, {QUOT_BITS{1'b0}}});
    sat      = prod_q >= lim;
    rem_ext  = {rem_q, lo_q[QUOT_BITS-1]};
    span_ext = {1'b0, span_eff};
    div_ge   = rem_ext >= span_ext;
    rem_next = div_ge ? TIME_BITS'(rem_ext - span_ext) : rem_ext[TIME_BITS-1:0];
    quo_next = {quo_q[QUOT_BITS-2:0], div_ge};
    bucket_div = (32'(quo_next) > 32'(w_m1)) ? BUCKET_BITS'(w_m1)
                                             : BUCKET_BITS'(quo_next);
  end

  always_comb begin
    state_d   = state_q;
    div_cnt_d = div_cnt_q;
    unique case (state_q)
      F_IDLE: begin
        if (in_valid_i) begin
          state_d = (pass || below) ? F_PUSH : F_MUL;
        end
      end
      F_MUL: state_d = F_CHK;
      F_CHK: begin
        if (sat) begin
          state_d = F_PUSH;
        end else begin
          state_d   = F_DIV;
          div_cnt_d = DIV_CNT_BITS'(QUOT_BITS - 1);
        end
      end
      F_DIV: begin
        if (div_cnt_q == '0) begin
          state_d = F_PUSH;
        end else begin
          div_cnt_d = div_cnt_q - DIV_CNT_BITS'(1);
        end
      end
      F_PUSH: begin
        if (!full_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= F_IDLE;
      div_cnt_q      <= '0;
      window_start_q <= '0;
      window_span_q  <= TIME_BITS'(1);
      pixel_width_q  <= '0;
      sample_count_q <= '0;
    end else begin
      state_q   <= state_d;
      div_cnt_q <= div_cnt_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_WINDOW_START: window_start_q <= cfg_data_i[TIME_BITS-1:0];
          CFG_WINDOW_SPAN:  window_span_q  <= cfg_data_i[TIME_BITS-1:0];
          CFG_PIXEL_WIDTH:  pixel_width_q  <= cfg_data_i[WIDTH_BITS-1:0];
          CFG_SAMPLE_COUNT: sample_count_q <= cfg_data_i[COUNT_BITS-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      F_IDLE: begin
        if (accept) begin
          stamp_q  <= sample_time_i;
          value_q  <= sample_value_i;
          last_q   <= last_sample_i;
          pass_q   <= pass;
          bucket_q <= '0;
          diff_q   <= sample_time_i - window_start_q;
        end
      end
      F_MUL: prod_q <= NUM_BITS'(PROD_BITS'(diff_q) * PROD_BITS'(w_eff));
      F_CHK: begin
        rem_q <= TIME_BITS'(prod_q >> QUOT_BITS);
        lo_q  <= prod_q[QUOT_BITS-1:0];
        quo_q <= '0;
        if (sat) begin
          bucket_q <= BUCKET_BITS'(w_m1);
        end
      end
      F_DIV: begin
        rem_q <= rem_next;
        lo_q  <= lo_q << 1;
        quo_q <= quo_next;
        if (div_cnt_q == '0) begin
          bucket_q <= bucket_div;
        end
      end
      default: ;
    endcase
  end

endmodule

/* design/mmbd_back.sv */
`timescale 1ns / 1ps
// Back end: per-column min/max tracking, flush sequencing and the output
// register. Depends on mmbd_pkg.
module mmbd_back (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   empty_i,
  input  mmbd_pkg::item_t                        item_i,
  output logic                                   pop_o,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic [mmbd_pkg::TIME_BITS-1:0]         point_time_o,
  output logic signed [mmbd_pkg::VALUE_BITS-1:0] point_value_o,
  output logic                                   last_point_o
);
  import mmbd_pkg::*;

  typedef enum logic [2:0] {B_IDLE, B_DEC, B_APPLY, B_F1, B_F2} state_e;

  state_e state_q, state_d;
  logic   open_q, open_d;
  logic   final_q, final_d;
  logic   out_valid_q, out_valid_d;

  item_t                        it_q;
  logic [BUCKET_BITS-1:0]       cur_q;
  logic signed [VALUE_BITS-1:0] min_val_q, max_val_q;
  logic [TIME_BITS-1:0]         min_time_q, max_time_q;
  logic [TIME_BITS-1:0]         point_time_q;
  logic signed [VALUE_BITS-1:0] point_value_q;
  logic                         last_point_q;

  logic                         out_free, out_load, out_last;
  logic [TIME_BITS-1:0]         out_time;
  logic signed [VALUE_BITS-1:0] out_value;
  logic                         new_col, upd_col;
  logic                         two, min_first;

  assign out_free      = !out_valid_q || !out_stall_i;
  assign pop_o         = (state_q == B_IDLE) && !empty_i;
  assign two           = min_val_q != max_val_q;
  assign min_first     = min_time_q <= max_time_q;
  assign out_valid_o   = out_valid_q;
  assign point_time_o  = point_time_q;
  assign point_value_o = point_value_q;
  assign last_point_o  = last_point_q;

  always_comb begin
    state_d   = state_q;
    open_d    = open_q;
    final_d   = final_q;
    out_load  = 1'b0;
    out_time  = it_q.stamp;
    out_value = it_q.value;
    out_last  = it_q.last;
    new_col   = 1'b0;
    upd_col   = 1'b0;
    unique case (state_q)
      B_IDLE: begin
        if (!empty_i) begin
          state_d = B_DEC;
        end
      end
      B_DEC: begin
        if (it_q.pass) begin
          if (out_free) begin
            out_load = 1'b1;
            if (it_q.last) begin
              open_d = 1'b0;
            end
            state_d = B_IDLE;
          end
        end else if (open_q && (it_q.bucket != cur_q)) begin
          final_d = 1'b0;
          state_d = B_F1;
        end else begin
          state_d = B_APPLY;
        end
      end
      B_APPLY: begin
        if (!open_q || (it_q.bucket != cur_q)) begin
          new_col = 1'b1;
          open_d  = 1'b1;
        end else begin
          upd_col = 1'b1;
        end
        if (it_q.last) begin
          final_d = 1'b1;
          state_d = B_F1;
        end else begin
          state_d = B_IDLE;
        end
      end
      B_F1, B_F2: begin
        if (out_free) begin
          out_load = 1'b1;
          // Points leave in time order: the earlier of min and max first.
          if ((state_q == B_F1) == min_first) begin
            out_time  = min_time_q;
            out_value = min_val_q;
          end else begin
            out_time  = max_time_q;
            out_value = max_val_q;
          end
          out_last = (state_q == B_F1 && two) ? 1'b0 : final_q;
          if (state_q == B_F1 && two) begin
            state_d = B_F2;
          end else if (final_q) begin
            open_d  = 1'b0;
            state_d = B_IDLE;
          end else begin
            state_d = B_APPLY;
          end
        end
      end
      default: state_d = B_IDLE;
    endcase
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      open_q      <= 1'b0;
      final_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      open_q      <= open_d;
      final_q     <= final_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      it_q <= item_i;
    end
    if (new_col) begin
      cur_q      <= it_q.bucket;
      min_val_q  <= it_q.value;
      max_val_q  <= it_q.value;
      min_time_q <= it_q.stamp;
      max_time_q <= it_q.stamp;
    end
    if (upd_col) begin
      if ($signed(it_q.value) < min_val_q) begin
        min_val_q  <= it_q.value;
        min_time_q <= it_q.stamp;
      end
      if ($signed(it_q.value) > max_val_q) begin
        max_val_q  <= it_q.value;
        max_time_q <= it_q.stamp;
      end
    end
    if (out_load) begin
      point_time_q  <= out_time;
      point_value_q <= out_value;
      last_point_q  <= out_last;
    end
  end

  a_second_point_differs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_F2) |-> two) else $error("second flush point with equal min and max");
  a_flush_needs_column: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_F1) |-> open_q) else $error("flush of a column that is not open");
  a_final_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && out_last && !(state_q == B_DEC)) |=> !open_q)
    else $error("column still open after the final point");

endmodule

/* design/minmax_bucket_decimator.sv */
`timescale 1ns / 1ps
// Min/max peak-detect decimator, top level. Depends on mmbd_pkg, mmbd_front,
// mmbd_fifo and mmbd_back.
//
// Each timestamped sample is placed in a pixel column and, per column, the
// first-seen minimum and maximum are kept and sent out in time order when the
// column changes or the run ends; with passthrough selected every sample goes
// straight out. The front end takes no new sample until the last one is
// pushed. To bin a sample it goes through capture, one multiply, one range
// check, a 13-step bit-serial divider by the window span and the queue push;
// when the quotient would be 2^13 or more it skips the divider and takes
// the last column, and in passthrough or for samples before the window it
// goes from capture straight to the push. A full queue holds the front end
// in its push step. The back end works behind a two-entry request queue,
// and its output register lets it go on updating columns while a point
// waits to be taken. Configuration is written with cfg_valid_i; the port is
// always ready, and indexes past the sample count register are ignored.
module minmax_bucket_decimator (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [mmbd_pkg::CFG_ADDR_BITS-1:0]     cfg_index_i,
  input  logic [31:0]                            cfg_data_i,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [mmbd_pkg::TIME_BITS-1:0]         sample_time_i,
  input  logic signed [mmbd_pkg::VALUE_BITS-1:0] sample_value_i,
  input  logic                                   last_sample_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic [mmbd_pkg::TIME_BITS-1:0]         point_time_o,
  output logic signed [mmbd_pkg::VALUE_BITS-1:0] point_value_o,
  output logic                                   last_point_o
);
  import mmbd_pkg::*;

  logic  push, full, pop, empty;
  item_t push_item, head_item;

  mmbd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .sample_time_i (sample_time_i),
    .sample_value_i(sample_value_i),
    .last_sample_i (last_sample_i),
    .push_o        (push),
    .push_item_o   (push_item),
    .full_i        (full)
  );

  mmbd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .full_o (full),
    .pop_i  (pop),
    .item_o (head_item),
    .empty_o(empty)
  );

  mmbd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (empty),
    .item_i       (head_item),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .point_time_o (point_time_o),
    .point_value_o(point_value_o),
    .last_point_o (last_point_o)
  );

endmodule
